FILE: rtl/lrbs_pkg.sv
// Shared types, framing constants and the escape lookup for the log record byte stuffer.
package lrbs_pkg;

  // Record word kinds.
  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_PAYLOAD = 2'd1;
  localparam logic [1:0] MODE_END     = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  // Framing marks and flow control bytes.
  localparam logic [7:0] MARK_START = 8'hEB;
  localparam logic [7:0] MARK_ESC   = 8'hEC;
  localparam logic [7:0] MARK_TICK  = 8'hED;
  localparam logic [7:0] MARK_END   = 8'hEE;
  localparam logic [7:0] CTRL_XON   = 8'h11;
  localparam logic [7:0] CTRL_XOFF  = 8'h13;

  // Codes sent after the escape byte.
  localparam logic [2:0] CODE_START = 3'd0;
  localparam logic [2:0] CODE_ESC   = 3'd1;
  localparam logic [2:0] CODE_END   = 3'd2;
  localparam logic [2:0] CODE_TICK  = 3'd3;
  localparam logic [2:0] CODE_XON   = 3'd4;
  localparam logic [2:0] CODE_XOFF  = 3'd5;

  // Job queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } rec_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } ser_word_t;

  // One classified record word: up to three bytes, len counts them (1 to 3).
  typedef struct packed {
    logic [1:0]      len;
    logic [2:0][7:0] bytes;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } esc_t;

  function automatic esc_t escape_lookup(input logic [7:0] value);
    esc_t r;
    r.hit  = 1'b1;
    r.code = 8'h00;
    unique case (value)
      MARK_START: r.code = {5'd0, CODE_START};
      MARK_ESC:   r.code = {5'd0, CODE_ESC};
      MARK_END:   r.code = {5'd0, CODE_END};
      MARK_TICK:  r.code = {5'd0, CODE_TICK};
      CTRL_XON:   r.code = {5'd0, CODE_XON};
      CTRL_XOFF:  r.code = {5'd0, CODE_XOFF};
      default:    r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/lrbs_front.sv
// Front end: accepts record words, keeps the checksum and builds byte jobs.
module lrbs_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rec_valid,
  output logic                   rec_ready,
  input  lrbs_pkg::rec_word_t    rec,
  input  lrbs_pkg::queue_status_t qstat,
  output logic                   push,
  output lrbs_pkg::job_t         job
);
  import lrbs_pkg::*;

  logic [7:0] checksum;
  logic [7:0] checksum_next;
  logic       accept;
  esc_t       esc_data;
  esc_t       esc_sum;

  assign rec_ready = !qstat.full;
  assign accept    = rec_valid && rec_ready;
  assign push      = accept && (rec.mode != MODE_NONE);

  assign esc_data = escape_lookup(rec.data_byte);
  assign esc_sum  = escape_lookup(checksum);

  always_comb begin
    job           = '0;
    checksum_next = checksum;
    unique case (rec.mode)
      MODE_START: begin
        job.len       = 2'd2;
        job.bytes[0]  = MARK_START;
        job.bytes[1]  = rec.data_byte;
        checksum_next = rec.data_byte;
      end
      MODE_PAYLOAD: begin
        checksum_next = checksum + rec.data_byte;
        if (esc_data.hit) begin
          job.len      = 2'd2;
          job.bytes[0] = MARK_ESC;
          job.bytes[1] = esc_data.code;
        end else begin
          job.len      = 2'd1;
          job.bytes[0] = rec.data_byte;
        end
      end
      MODE_END: begin
        job.bytes[0] = MARK_END;
        if (esc_sum.hit) begin
          job.len      = 2'd3;
          job.bytes[1] = MARK_ESC;
          job.bytes[2] = esc_sum.code;
        end else begin
          job.len      = 2'd2;
          job.bytes[1] = checksum;
        end
      end
      default: begin
        job = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum <= 8'h00;
    end else if (accept) begin
      checksum <= checksum_next;
    end
  end

endmodule

FILE: rtl/lrbs_queue.sv
// Short job queue that decouples the front end from the byte sequencer.
module lrbs_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  lrbs_pkg::job_t          push_job,
  input  logic                    pop,
  output lrbs_pkg::job_t          head,
  output lrbs_pkg::queue_status_t qstat
);
  import lrbs_pkg::*;

  job_t                  slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("job queue read while empty");

endmodule

FILE: rtl/lrbs_back.sv
// Back end: walks each job one byte per cycle into the output register, while the receiver takes the bytes.
module lrbs_back (
  input  logic                    clk,
  input  logic                    rst,
  input  lrbs_pkg::job_t          head,
  input  lrbs_pkg::queue_status_t qstat,
  output logic                    pop,
  output logic                    ser_valid,
  input  logic                    ser_ready,
  output lrbs_pkg::ser_word_t     ser
);
  import lrbs_pkg::*;

  job_t       cur;
  logic [1:0] idx;
  logic       busy;
  logic       slot_free;
  logic       cur_last;

  assign slot_free = !ser_valid || ser_ready;
  assign cur_last  = (idx == cur.len - 2'd1);
  assign pop       = slot_free && !busy && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      busy      <= 1'b0;
    end else if (slot_free) begin
      if (busy) begin
        ser_valid    <= 1'b1;
        ser.out_byte <= cur.bytes[idx];
        ser.last     <= cur_last;
        idx          <= idx + 2'd1;
        if (cur_last) begin
          busy <= 1'b0;
        end
      end else if (!qstat.empty) begin
        ser_valid    <= 1'b1;
        ser.out_byte <= head.bytes[0];
        ser.last     <= (head.len == 2'd1);
        if (head.len != 2'd1) begin
          cur  <= head;
          idx  <= 2'd1;
          busy <= 1'b1;
        end
      end else begin
        ser_valid <= 1'b0;
      end
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx < cur.len))
    else $error("byte index beyond job length");

  a_tail_pending: assert property (@(posedge clk) disable iff (rst)
    (ser_valid && !ser.last) |-> busy)
    else $error("non-final byte shown with no rest of job pending");

endmodule

FILE: rtl/log_record_byte_stuffer.sv
// Top level of the log record byte stuffer: front end, job queue and byte sequencer.
//
// The rec channel takes one record word per handshake: a start word (mode 0)
// carrying the message type, a payload word (mode 1) carrying one data byte,
// or an end word (mode 2). Mode 3 is accepted and dropped. The ser channel
// gives one serial byte per handshake, with last set on the final byte that a
// record word causes. Start words give the start mark and the raw type; payload
// bytes and the closing checksum are escaped as the escape byte plus a code.
//
// A record word is classified and its bytes are worked out in the cycle it is
// accepted, then queued in a four-entry job queue; the first byte goes from
// there to the output register. While ser_ready is high the sequencer sends
// one byte per cycle with no gap between words, a word giving one to three
// bytes, and input words are taken every cycle while the queue has room.
//
// Reset clears the checksum to zero and empties the queue and output register.
// When the receiver holds ser_ready low the current byte stays on ser, the
// queue fills, and rec_ready drops once all four entries are taken.
module log_record_byte_stuffer (
  input  logic                clk,
  input  logic                rst,
  input  logic                rec_valid,
  output logic                rec_ready,
  input  lrbs_pkg::rec_word_t rec,
  output logic                ser_valid,
  input  logic                ser_ready,
  output lrbs_pkg::ser_word_t ser
);
  import lrbs_pkg::*;

  queue_status_t qstat;
  job_t          push_job;
  job_t          head;
  logic          push;
  logic          pop;

  // Classification and checksum.
  lrbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .qstat     (qstat),
    .push      (push),
    .job       (push_job)
  );

  // Job queue lets either side stall on its own.
  lrbs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // Byte sequencer and output register.
  lrbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .ser_valid (ser_valid),
    .ser_ready (ser_ready),
    .ser       (ser)
  );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the log record byte stuffer: random records in, bytes checked.
`timescale 1ns / 100ps

module tb;
  import lrbs_pkg::*;

  // Run length guard. It leaves a wide margin over a correct run, even with
  // heavy receiver stalls.
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 8;

  // A record word waiting to go out. When hold is set the sender waits, before
  // offering this word, until every serial byte predicted so far has arrived.
  typedef struct {
    rec_word_t word;
    bit        hold;
  } pending_word_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      rec_valid = 1'b0;
  logic      rec_ready;
  rec_word_t rec       = '0;
  logic      ser_valid;
  logic      ser_ready = 1'b0;
  ser_word_t ser;

  log_record_byte_stuffer dut (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .ser_valid (ser_valid),
    .ser_ready (ser_ready),
    .ser       (ser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Words still to be offered, and serial bytes still to be received.
  pending_word_t rec_backlog[$];
  ser_word_t     awaited_bytes[$];
  pending_word_t next_up;

  // Checksum as the block should hold it, updated as each word is accepted.
  logic [7:0] run_sum;
  // Checksum as seen by the stimulus generator, so that it can steer the
  // closing checksum of a record onto a byte that needs escaping.
  logic [7:0] gen_sum;

  // Idle rates, in percent, for the sender and the receiver.
  int send_idle_pct;
  int recv_idle_pct;

  int issued_cnt;
  int accepted_cnt;
  int live_words;
  int bytes_checked;
  int errors;
  int cycle_cnt;
  int n_start;
  int n_payload;
  int n_end;
  int n_dropped;
  int n_escapes;

  // Appends one expected serial byte.
  function automatic void await_byte(input logic [7:0] b, input logic is_last);
    ser_word_t w;
    w.out_byte = b;
    w.last     = is_last;
    awaited_bytes.push_back(w);
  endfunction

  // Appends a byte as it must appear on the line: the six reserved values are
  // replaced by the escape byte and their code, and last goes on the final byte.
  function automatic void await_escaped(input logic [7:0] b);
    logic [2:0] code;
    bit         hit;
    hit  = 1'b1;
    code = CODE_START;
    case (b)
      MARK_START: code = CODE_START;
      MARK_ESC:   code = CODE_ESC;
      MARK_END:   code = CODE_END;
      MARK_TICK:  code = CODE_TICK;
      CTRL_XON:   code = CODE_XON;
      CTRL_XOFF:  code = CODE_XOFF;
      default:    hit  = 1'b0;
    endcase
    if (hit) begin
      await_byte(MARK_ESC, 1'b0);
      await_byte({5'd0, code}, 1'b1);
      n_escapes++;
    end else begin
      await_byte(b, 1'b1);
    end
  endfunction

  // Works out the serial bytes that one accepted record word causes and
  // advances the running checksum.
  function automatic void stuff_record_word(input rec_word_t w);
    case (w.mode)
      MODE_START: begin
        // The type byte goes out raw, even when it is a reserved value.
        run_sum = w.data_byte;
        await_byte(MARK_START, 1'b0);
        await_byte(w.data_byte, 1'b1);
        n_start++;
      end
      MODE_PAYLOAD: begin
        run_sum = run_sum + w.data_byte;
        await_escaped(w.data_byte);
        n_payload++;
      end
      MODE_END: begin
        // The checksum is left as it is, so a repeated end sends it again.
        await_byte(MARK_END, 1'b0);
        await_escaped(run_sum);
        n_end++;
      end
      default: begin
        n_dropped++;
      end
    endcase
  endfunction

  function automatic logic [7:0] reserved_byte(input int k);
    case (k)
      0:       return MARK_START;
      1:       return MARK_ESC;
      2:       return MARK_END;
      3:       return MARK_TICK;
      4:       return CTRL_XON;
      default: return CTRL_XOFF;
    endcase
  endfunction

  // At least a quarter of the random bytes are reserved values, so escaping is common.
  function automatic logic [7:0] random_byte();
    if ($urandom_range(0, 3) == 0) begin
      return reserved_byte($urandom_range(0, 5));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic enqueue_word(input logic [1:0] m, input logic [7:0] d, input bit hold);
    pending_word_t p;
    p.word.mode      = m;
    p.word.data_byte = d;
    p.hold           = hold;
    rec_backlog.push_back(p);
    issued_cnt++;
    if (m != MODE_NONE) begin
      live_words++;
    end
    if (m == MODE_START) begin
      gen_sum = d;
    end else if (m == MODE_PAYLOAD) begin
      gen_sum = gen_sum + d;
    end
  endtask

  // Mostly well-formed records with random content; the rest is noise: dropped
  // words, payload outside a record and stray ends.
  task automatic fill_random(input int n_words);
    int target;
    int len;
    int roll;
    target = live_words + n_words;
    while (live_words < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        enqueue_word(MODE_START, random_byte(), $urandom_range(0, 19) == 0);
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
          enqueue_word(MODE_PAYLOAD, random_byte(), 1'b0);
        end
        // Now and then pick the last payload byte so that the checksum itself
        // is a reserved value and must be escaped after the end mark.
        if ($urandom_range(0, 3) == 0) begin
          enqueue_word(MODE_PAYLOAD, reserved_byte($urandom_range(0, 5)) - gen_sum, 1'b0);
        end
        enqueue_word(MODE_END, 8'($urandom_range(0, 255)), 1'b0);
      end else if (roll < 90) begin
        enqueue_word(MODE_NONE, 8'($urandom_range(0, 255)), 1'b0);
      end else if (roll < 95) begin
        enqueue_word(MODE_PAYLOAD, random_byte(), 1'b0);
      end else begin
        enqueue_word(MODE_END, 8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  // Waits until every queued word has been taken and every byte has come out.
  task automatic wait_drained();
    while (accepted_cnt != issued_cnt || awaited_bytes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic void next_byte_check(input ser_word_t exp_w);
    if (ser.out_byte !== exp_w.out_byte || ser.last !== exp_w.last) begin
      if (errors < MAX_REPORTS) begin
        $display("ERROR: serial byte %0d: expected out_byte %h last %b,",
                 bytes_checked, exp_w.out_byte, exp_w.last,
                 " got out_byte %h last %b", ser.out_byte, ser.last);
      end
      errors++;
    end
  endfunction

  // Sender. A word accepted at this edge is handed to the predictor; then,
  // if the channel is free, the next word is offered unless the sender idles
  // or the word at the front must wait for the output to run dry.
  always @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else begin
      if (rec_valid && rec_ready) begin
        stuff_record_word(rec);
        accepted_cnt++;
      end
      if (!rec_valid || rec_ready) begin
        if (rec_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(rec_backlog[0].hold && awaited_bytes.size() != 0)) begin
          next_up = rec_backlog.pop_front();
          rec       <= next_up.word;
          rec_valid <= 1'b1;
        end else begin
          rec_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each serial byte taken is compared with the oldest expectation,
  // field by field; ready is then redrawn for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      ser_ready <= 1'b0;
    end else begin
      if (ser_valid && ser_ready) begin
        if (awaited_bytes.size() == 0) begin
          if (errors < MAX_REPORTS) begin
            $display("ERROR: unexpected serial byte %h last %b", ser.out_byte, ser.last);
          end
          errors++;
        end else begin
          next_byte_check(awaited_bytes.pop_front());
        end
        bytes_checked++;
      end
      ser_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("ERROR: run stopped after %0d cycles with %0d bytes outstanding",
               cycle_cnt, awaited_bytes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    run_sum       = 8'h00;
    gen_sum       = 8'h00;
    send_idle_pct = 19;
    recv_idle_pct = 77;

    // Directed words, queued while reset is still held. They open with an
    // end and a payload before any start, so the checksum left by reset is
    // used; then a dropped word, a start whose type is a reserved value and
    // goes out raw, payload bytes at both extremes and all six reserved
    // values, repeated ends, a checksum that must be escaped (with a pause
    // for the output to run dry first), and a checksum that wraps past 255.
    enqueue_word(MODE_END,     8'h00, 1'b0);
    enqueue_word(MODE_PAYLOAD, 8'h05, 1'b0);
    enqueue_word(MODE_END,     8'hFF, 1'b0);
    enqueue_word(MODE_NONE,    8'hAA, 1'b0);
    enqueue_word(MODE_START,   MARK_START, 1'b0);
    enqueue_word(MODE_PAYLOAD, 8'h00, 1'b0);
    enqueue_word(MODE_PAYLOAD, 8'hFF, 1'b0);
    for (int k = 0; k < 6; k++) begin
      enqueue_word(MODE_PAYLOAD, reserved_byte(k), 1'b0);
    end
    enqueue_word(MODE_END,     8'h00, 1'b0);
    enqueue_word(MODE_END,     8'hFF, 1'b0);
    enqueue_word(MODE_START,   CTRL_XOFF, 1'b1);
    enqueue_word(MODE_END,     8'h00, 1'b0);
    enqueue_word(MODE_START,   8'hF0, 1'b0);
    enqueue_word(MODE_PAYLOAD, 8'h20, 1'b0);
    enqueue_word(MODE_END,     8'h00, 1'b0);
    enqueue_word(MODE_START,   8'hFF, 1'b0);
    enqueue_word(MODE_NONE,    8'h55, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Phase one: the receiver stalls most of the time, the sender seldom.
    fill_random(50);
    wait_drained();

    // Phase two: the sender is the slow side.
    send_idle_pct = 77;
    recv_idle_pct = 19;
    fill_random(50);
    wait_drained();

    // Phase three: both sides run flat out.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(50);
    wait_drained();

    // Let a trailing dropped word pass through before the final check.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_bytes.size() != 0) begin
      $display("ERROR: %0d serial bytes never arrived", awaited_bytes.size());
      errors++;
    end

    $display("Sent %0d record words: %0d starts, %0d payloads, %0d ends, %0d dropped.",
             accepted_cnt, n_start, n_payload, n_end, n_dropped);
    $display("Checked %0d serial bytes, %0d escape pairs among them, in %0d cycles.",
             bytes_checked, n_escapes, cycle_cnt);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lrbs_pkg.sv
rtl/lrbs_front.sv
rtl/lrbs_queue.sv
rtl/lrbs_back.sv
rtl/log_record_byte_stuffer.sv
dv/tb.sv
